// ----- src/mvm_pkg.sv -----
// ----------------------------------------------------------------------------
// mvm_pkg
// Shared types, constants and helpers of the matrix-vector multiplier.
// ----------------------------------------------------------------------------
package mvm_pkg;

	localparam int IDX_W       = 6;
	localparam int VAL_W       = 16;
	localparam int PROD_W      = 2 * VAL_W;
	localparam int SUM_W       = 38;
	localparam int SIZE_W      = 7;
	localparam int STORE_DEPTH = 64;
	localparam int MAX_COLS    = 64;
	localparam int MAX_ROWS    = 64;
	localparam int QUEUE_DEPTH = 4;

	localparam int COL_LIMIT = (MAX_COLS < STORE_DEPTH) ? MAX_COLS : STORE_DEPTH;
	localparam int ROW_LIMIT = (MAX_ROWS < STORE_DEPTH) ? MAX_ROWS : STORE_DEPTH;

	// Input beat kinds carried on tuser.
	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_MATRIX = 1'b1;

	// Configuration register indexes.
	localparam logic REG_COLS = 1'b0;
	localparam logic REG_ROWS = 1'b1;

	typedef struct packed {
		logic [SIZE_W-1:0] ncols;
		logic [SIZE_W-1:0] nrows;
	} sizes_t;

	// One matrix element on its way to the multiply-accumulate.
	typedef struct packed {
		logic signed [VAL_W-1:0] mat;
		logic signed [VAL_W-1:0] vec;
		logic                    end_row;
		logic [IDX_W-1:0]        row;
		logic                    last;
	} work_t;

	// A size of zero acts as one; anything above the limit saturates.
	function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] r,
			input logic [SIZE_W-1:0] lim);
		logic [SIZE_W-1:0] n;
		n = (r == '0) ? SIZE_W'(1) : r;
		if (n > lim) begin
			n = lim;
		end
		return n;
	endfunction

endpackage

// ----- src/matrix_vector_multiply.sv -----
// ----------------------------------------------------------------------------
// matrix_vector_multiply
// Streams a vector into a store, then multiplies row-major matrix beats with
// it and emits one Q22.16 dot product per row.
//
//   channel  dir  signals                                  content
//   s_       in   s_tvalid s_tready s_tdata s_tuser        vector load / matrix
//   m_       out  m_tvalid m_tready m_tdata m_tlast        row sum per row
//   cfg_     in   cfg_we cfg_index cfg_wdata               column and row count
//
// One input beat is taken every cycle while the output side keeps up; a row
// sum goes from the beat that ends its row through the store read, the queue,
// the multiply and then the accumulate into the output register.
// Reset clears counters, accumulator and handshake state; the vector store
// holds no reset value and must be loaded before use.
// A stalled output stops the back end; the four-entry queue then fills
// before the input side stalls.
// ----------------------------------------------------------------------------
module matrix_vector_multiply #(
	parameter int MAX_COLS = mvm_pkg::MAX_COLS,
	parameter int MAX_ROWS = mvm_pkg::MAX_ROWS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [23:0]                 s_tdata,   // index[5:0], value[21:6], zero pad
	input  logic                        s_tuser,   // command
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [47:0]                 m_tdata,   // row_sum[37:0], row_number[43:38], pad
	output logic                        m_tlast,   // last_row
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [mvm_pkg::SIZE_W-1:0]  cfg_wdata
);

	localparam logic [mvm_pkg::SIZE_W-1:0] COL_LIM = mvm_pkg::SIZE_W'(
		(MAX_COLS < mvm_pkg::STORE_DEPTH) ? MAX_COLS : mvm_pkg::STORE_DEPTH);
	localparam logic [mvm_pkg::SIZE_W-1:0] ROW_LIM = mvm_pkg::SIZE_W'(
		(MAX_ROWS < mvm_pkg::STORE_DEPTH) ? MAX_ROWS : mvm_pkg::STORE_DEPTH);

	mvm_pkg::sizes_t sizes_q;

	logic                              work_valid;
	logic                              work_ready;
	mvm_pkg::work_t                    work;
	logic                              q_valid;
	logic                              q_ready;
	mvm_pkg::work_t                    q_data;
	logic signed [mvm_pkg::SUM_W-1:0]  out_sum;
	logic [mvm_pkg::IDX_W-1:0]         out_row;

	// Sizes are stored already clamped to their usable range.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sizes_q.ncols <= mvm_pkg::eff_size(mvm_pkg::SIZE_W'(64), COL_LIM);
			sizes_q.nrows <= mvm_pkg::eff_size(mvm_pkg::SIZE_W'(64), ROW_LIM);
		end else if (cfg_we) begin
			unique case (cfg_index)
				mvm_pkg::REG_COLS: sizes_q.ncols <= mvm_pkg::eff_size(cfg_wdata, COL_LIM);
				mvm_pkg::REG_ROWS: sizes_q.nrows <= mvm_pkg::eff_size(cfg_wdata, ROW_LIM);
				default: ;
			endcase
		end
	end

	mvm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.sizes      (sizes_q),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_cmd     (s_tuser),
		.in_index   (s_tdata[5:0]),
		.in_value   (s_tdata[21:6]),
		.work_valid (work_valid),
		.work_ready (work_ready),
		.work       (work)
	);

	mvm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (work_valid),
		.push_ready (work_ready),
		.push_data  (work),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (q_data)
	);

	mvm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.work_valid (q_valid),
		.work_ready (q_ready),
		.work       (q_data),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_sum    (out_sum),
		.out_row    (out_row),
		.out_last   (m_tlast)
	);

	assign m_tdata = {4'b0000, out_row, out_sum};

endmodule

// ----- src/mvm_front.sv -----
// ----------------------------------------------------------------------------
// mvm_front
// Accepts input beats, writes vector loads into the vector store and turns
// matrix beats into work entries with their vector operand and row position.
// ----------------------------------------------------------------------------
module mvm_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  mvm_pkg::sizes_t                      sizes,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 in_cmd,
	input  logic [mvm_pkg::IDX_W-1:0]            in_index,
	input  logic signed [mvm_pkg::VAL_W-1:0]     in_value,
	output logic                                 work_valid,
	input  logic                                 work_ready,
	output mvm_pkg::work_t                       work
);

	logic [mvm_pkg::VAL_W-1:0] vstore [mvm_pkg::STORE_DEPTH];

	logic [mvm_pkg::IDX_W-1:0] col_q;
	logic [mvm_pkg::IDX_W-1:0] row_q;

	logic                             valid_s1;
	logic signed [mvm_pkg::VAL_W-1:0] mat_s1;
	logic signed [mvm_pkg::VAL_W-1:0] vec_s1;
	logic                             end_row_s1;
	logic [mvm_pkg::IDX_W-1:0]        row_s1;
	logic                             last_s1;

	logic advance;
	logic fire;
	logic is_matrix;
	logic end_row;
	logic last;

	assign advance   = !valid_s1 || work_ready;
	assign in_ready  = advance;
	assign fire      = in_valid && advance;
	assign is_matrix = (in_cmd == mvm_pkg::CMD_MATRIX);

	assign end_row = ({1'b0, col_q} + mvm_pkg::SIZE_W'(1)) >= sizes.ncols;
	assign last    = ({1'b0, row_q} + mvm_pkg::SIZE_W'(1)) >= sizes.nrows;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (advance) begin
				valid_s1 <= fire && is_matrix;
			end
			if (fire && is_matrix) begin
				if (end_row) begin
					col_q <= '0;
					row_q <= last ? '0 : row_q + mvm_pkg::IDX_W'(1);
				end else begin
					col_q <= col_q + mvm_pkg::IDX_W'(1);
				end
			end
		end
	end

	// A load written at one edge is seen by a matrix read at the next edge,
	// so beat order is kept without any bypass.
	always_ff @(posedge clk) begin
		if (fire && !is_matrix) begin
			vstore[in_index] <= in_value;
		end
		if (fire && is_matrix) begin
			vec_s1     <= vstore[col_q];
			mat_s1     <= in_value;
			end_row_s1 <= end_row;
			row_s1     <= row_q;
			last_s1    <= last;
		end
	end

	assign work_valid   = valid_s1;
	assign work.mat     = mat_s1;
	assign work.vec     = vec_s1;
	assign work.end_row = end_row_s1;
	assign work.row     = row_s1;
	assign work.last    = last_s1;

endmodule

// ----- src/mvm_queue.sv -----
// ----------------------------------------------------------------------------
// mvm_queue
// Short first-in first-out buffer of work entries between front and back.
// ----------------------------------------------------------------------------
module mvm_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  mvm_pkg::work_t  push_data,
	output logic            pop_valid,
	input  logic            pop_ready,
	output mvm_pkg::work_t  pop_data
);

	localparam int PTR_W = $clog2(mvm_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(mvm_pkg::QUEUE_DEPTH + 1);

	mvm_pkg::work_t entries_q [mvm_pkg::QUEUE_DEPTH];

	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic push;
	logic pop;

	assign push_ready = (count_q != CNT_W'(mvm_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- src/mvm_back.sv -----
// ----------------------------------------------------------------------------
// mvm_back
// Multiplies each work entry, accumulates the row and holds the finished
// row sum in the output register.
// ----------------------------------------------------------------------------
module mvm_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              work_valid,
	output logic                              work_ready,
	input  mvm_pkg::work_t                    work,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [mvm_pkg::SUM_W-1:0]  out_sum,
	output logic [mvm_pkg::IDX_W-1:0]         out_row,
	output logic                              out_last
);

	logic                              valid_s2;
	logic signed [mvm_pkg::PROD_W-1:0] prod_s2;
	logic                              end_row_s2;
	logic [mvm_pkg::IDX_W-1:0]         row_s2;
	logic                              last_s2;

	logic signed [mvm_pkg::SUM_W-1:0]  acc_q;
	logic                              out_valid_q;
	logic signed [mvm_pkg::SUM_W-1:0]  out_sum_q;
	logic [mvm_pkg::IDX_W-1:0]         out_row_q;
	logic                              out_last_q;

	logic                              en;
	logic signed [mvm_pkg::SUM_W-1:0]  sum;

	// The whole back end moves only while the output register can take a beat.
	assign en         = !out_valid_q || out_ready;
	assign work_ready = en;
	assign sum        = acc_q + mvm_pkg::SUM_W'(prod_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s2    <= work_valid;
			out_valid_q <= valid_s2 && end_row_s2;
			if (valid_s2) begin
				acc_q <= end_row_s2 ? '0 : sum;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && work_valid) begin
			prod_s2    <= work.mat * work.vec;
			end_row_s2 <= work.end_row;
			row_s2     <= work.row;
			last_s2    <= work.last;
		end
		if (en && valid_s2 && end_row_s2) begin
			out_sum_q  <= sum;
			out_row_q  <= row_s2;
			out_last_q <= last_s2;
		end
	end

	assign out_valid = out_valid_q;
	assign out_sum   = out_sum_q;
	assign out_row   = out_row_q;
	assign out_last  = out_last_q;

endmodule
